@@ hw/rtl/mcqp_pkg.sv @@
// ----------------------------------------------------------------------------
// mcqp_pkg: shared types and constants for the motor command quantizer
// Register indexes, reset values, code widths and pipeline depths used by the
// lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package mcqp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_POS_MIN       = 3'd0,
    REG_POS_MAX       = 3'd1,
    REG_VEL_MIN       = 3'd2,
    REG_VEL_MAX       = 3'd3,
    REG_TORQUE_MIN    = 3'd4,
    REG_TORQUE_MAX    = 3'd5,
    REG_STIFFNESS_MAX = 3'd6,
    REG_DAMPING_MAX   = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic signed [31:0] POS_MIN_RST    = -32'sd819200;
  localparam logic signed [31:0] POS_MAX_RST    = 32'sd819200;
  localparam logic signed [31:0] VEL_MIN_RST    = -32'sd1966080;
  localparam logic signed [31:0] VEL_MAX_RST    = 32'sd1966080;
  localparam logic signed [31:0] TORQUE_MIN_RST = -32'sd655360;
  localparam logic signed [31:0] TORQUE_MAX_RST = 32'sd655360;
  localparam logic [30:0]        STIFF_MAX_RST  = 31'd32768000;
  localparam logic [30:0]        DAMP_MAX_RST   = 31'd327680;

  // fixed lower bounds of the gain ranges and the frame id offset
  localparam logic signed [32:0] STIFFNESS_LOW = 33'sd0;
  localparam logic signed [32:0] DAMPING_LOW   = 33'sd0;
  localparam logic [10:0]        MODE_OFFSET   = 11'd0;

  // code widths and full-scale values
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned LOW_BITS = 12;
  localparam logic [15:0] POS_FULL = 16'((64'd1 << POS_BITS) - 64'd1);
  localparam logic [15:0] LOW_FULL = 16'((64'd1 << LOW_BITS) - 64'd1);

  // lane pipeline: clamp stage, multiply stage, one stage per quotient bit
  localparam int unsigned DIV_STEPS = POS_BITS;
  localparam int unsigned LANE_LAT  = 2 + DIV_STEPS;
  // from accepted command to result strobe (merge register included)
  localparam int unsigned TOTAL_LAT = LANE_LAT + 1;

  // the five lane results handed to the merge stage
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] vel;
    logic [15:0] stiff;
    logic [15:0] damp;
    logic [15:0] torque;
  } codes_t;

endpackage

@@ hw/rtl/mit_command_quantize_pack_unit.sv @@
// ----------------------------------------------------------------------------
// mit_command_quantize_pack_unit: motor command quantizer and frame packer
// Usage:
//   A command word is taken at each clock edge with start high; busy is
//   always low, so a new word may follow every cycle.
//   Five lanes clamp and quantize position, velocity, stiffness, damping and
//   torque in parallel; the merge stage packs the codes into the payload.
//   Latency: 19 register stages (clamp, multiply, 16 divider stages, packing
//   register). Throughput: one word per cycle, set by the fully pipelined
//   per-lane divider. Each result word is on out_bus_id / out_payload for
//   exactly one cycle with out_strobe high; the receiver cannot stall it.
//   Range registers are written through cfg_we / cfg_index / cfg_wdata while
//   no word is in flight; they take effect for words accepted afterwards.
//   Synchronous reset (rst_n low) loads the default ranges and drops all
//   words in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mit_command_quantize_pack_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [10:0]              in_motor_number,
  input  logic signed [31:0]       in_target_position,
  input  logic signed [31:0]       in_target_velocity,
  input  logic signed [31:0]       in_stiffness,
  input  logic signed [31:0]       in_damping,
  input  logic signed [31:0]       in_feed_torque,
  // result channel
  output logic                     out_strobe,
  output logic [10:0]              out_bus_id,
  output logic [63:0]              out_payload,
  // configuration port
  input  logic                     cfg_we,
  input  mcqp_pkg::cfg_reg_t       cfg_index,
  input  logic [31:0]              cfg_wdata
);

  localparam int unsigned LAT = mcqp_pkg::LANE_LAT;

  // range registers
  logic signed [31:0] pos_min_r, pos_max_r, vel_min_r, vel_max_r;
  logic signed [31:0] torque_min_r, torque_max_r;
  logic        [30:0] stiff_max_r, damp_max_r;

  logic               accept;
  logic [10:0]        bus_id_nxt;
  logic               vld_r [0:LAT-1];
  logic [10:0]        fid_r [0:LAT-1];
  mcqp_pkg::codes_t   codes;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r    <= mcqp_pkg::POS_MIN_RST;
      pos_max_r    <= mcqp_pkg::POS_MAX_RST;
      vel_min_r    <= mcqp_pkg::VEL_MIN_RST;
      vel_max_r    <= mcqp_pkg::VEL_MAX_RST;
      torque_min_r <= mcqp_pkg::TORQUE_MIN_RST;
      torque_max_r <= mcqp_pkg::TORQUE_MAX_RST;
      stiff_max_r  <= mcqp_pkg::STIFF_MAX_RST;
      damp_max_r   <= mcqp_pkg::DAMP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcqp_pkg::REG_POS_MIN:       pos_min_r    <= cfg_wdata;
        mcqp_pkg::REG_POS_MAX:       pos_max_r    <= cfg_wdata;
        mcqp_pkg::REG_VEL_MIN:       vel_min_r    <= cfg_wdata;
        mcqp_pkg::REG_VEL_MAX:       vel_max_r    <= cfg_wdata;
        mcqp_pkg::REG_TORQUE_MIN:    torque_min_r <= cfg_wdata;
        mcqp_pkg::REG_TORQUE_MAX:    torque_max_r <= cfg_wdata;
        mcqp_pkg::REG_STIFFNESS_MAX: stiff_max_r  <= cfg_wdata[30:0];
        mcqp_pkg::REG_DAMPING_MAX:   damp_max_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // frame id, wrapped to 11 bits
  assign bus_id_nxt = 11'(in_motor_number + mcqp_pkg::MODE_OFFSET);

  // word tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    fid_r[0] <= bus_id_nxt;
    for (int i = 1; i < LAT; i++) begin
      fid_r[i] <= fid_r[i-1];
    end
  end

  // quantizer lanes
  mcqp_lane u_lane_pos (
    .clk    (clk),
    .x_i    (in_target_position),
    .lo_i   ({pos_min_r[31], pos_min_r}),
    .hi_i   ({pos_max_r[31], pos_max_r}),
    .full_i (mcqp_pkg::POS_FULL),
    .code_o (codes.pos)
  );

  mcqp_lane u_lane_vel (
    .clk    (clk),
    .x_i    (in_target_velocity),
    .lo_i   ({vel_min_r[31], vel_min_r}),
    .hi_i   ({vel_max_r[31], vel_max_r}),
    .full_i (mcqp_pkg::LOW_FULL),
    .code_o (codes.vel)
  );

  mcqp_lane u_lane_stiff (
    .clk    (clk),
    .x_i    (in_stiffness),
    .lo_i   (mcqp_pkg::STIFFNESS_LOW),
    .hi_i   ({2'b00, stiff_max_r}),
    .full_i (mcqp_pkg::LOW_FULL),
    .code_o (codes.stiff)
  );

  mcqp_lane u_lane_damp (
    .clk    (clk),
    .x_i    (in_damping),
    .lo_i   (mcqp_pkg::DAMPING_LOW),
    .hi_i   ({2'b00, damp_max_r}),
    .full_i (mcqp_pkg::LOW_FULL),
    .code_o (codes.damp)
  );

  mcqp_lane u_lane_torque (
    .clk    (clk),
    .x_i    (in_feed_torque),
    .lo_i   ({torque_min_r[31], torque_min_r}),
    .hi_i   ({torque_max_r[31], torque_max_r}),
    .full_i (mcqp_pkg::LOW_FULL),
    .code_o (codes.torque)
  );

  // pack and register the result word
  mcqp_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_r[LAT-1]),
    .bus_id_i    (fid_r[LAT-1]),
    .codes_i     (codes),
    .out_strobe  (out_strobe),
    .out_bus_id  (out_bus_id),
    .out_payload (out_payload)
  );

  // a result word only follows an accepted command, at fixed latency
  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, mcqp_pkg::TOTAL_LAT))
    else $error("result strobe without a matching command");

  // frame id travels with its word
  a_bus_id_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_bus_id == $past(bus_id_nxt, mcqp_pkg::TOTAL_LAT))
    else $error("frame id out of step with payload");

  // 12-bit lanes never produce a quotient above their full scale
  a_low_codes_fit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |-> (codes.vel[15:12] == 4'd0) && (codes.stiff[15:12] == 4'd0) &&
                     (codes.damp[15:12] == 4'd0) && (codes.torque[15:12] == 4'd0))
    else $error("12-bit lane quotient overflow");

endmodule

@@ hw/rtl/mcqp_lane.sv @@
// ----------------------------------------------------------------------------
// mcqp_lane: one quantizer lane
// Clamps a signed value to [lo, hi], scales it by the full-scale code and
// divides by the range width in a pipelined restoring divider, one quotient
// bit per stage. An empty or inverted range gives code zero.
// ----------------------------------------------------------------------------
module mcqp_lane (
  input  logic                clk,
  input  logic signed [31:0]  x_i,
  input  logic signed [32:0]  lo_i,
  input  logic signed [32:0]  hi_i,
  input  logic        [15:0]  full_i,
  output logic        [15:0]  code_o
);

  localparam int unsigned NS = mcqp_pkg::DIV_STEPS;

  // clamp stage signals
  logic signed [32:0] x_ext;
  logic signed [32:0] x_clamp;
  logic signed [32:0] num_diff;
  logic signed [32:0] den_diff;
  logic               range_bad;
  logic        [31:0] num_nxt, num_r;
  logic        [31:0] den_nxt, den1_r;

  // multiply stage
  logic        [47:0] prod_nxt;

  // divider stage registers
  logic [31:0] rem_r [0:NS-1];
  logic [15:0] low_r [0:NS-1];
  logic [31:0] den_r [0:NS-1];
  logic [15:0] q_r   [1:NS];

  // clamp to range, form numerator and divisor
  always_comb begin
    x_ext     = {x_i[31], x_i};
    range_bad = (hi_i <= lo_i);
    if (x_ext < lo_i) begin
      x_clamp = lo_i;
    end else if (x_ext > hi_i) begin
      x_clamp = hi_i;
    end else begin
      x_clamp = x_ext;
    end
    num_diff = x_clamp - lo_i;
    den_diff = hi_i - lo_i;
    if (range_bad) begin
      num_nxt = 32'd0;
      den_nxt = 32'd1;
    end else begin
      num_nxt = num_diff[31:0];
      den_nxt = den_diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den1_r <= den_nxt;
  end

  // scale by full-scale code
  assign prod_nxt = num_r * full_i;

  always_ff @(posedge clk) begin
    rem_r[0] <= prod_nxt[47:16];
    low_r[0] <= prod_nxt[15:0];
    den_r[0] <= den1_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < NS; i++) begin : g_div
    logic [32:0] trial;
    logic        take;
    logic [15:0] q_prev;

    always_comb begin
      trial = {rem_r[i], low_r[i][15]};
      take  = (trial >= {1'b0, den_r[i]});
    end

    if (i == 0) begin : g_first
      assign q_prev = 16'd0;
    end else begin : g_rest
      assign q_prev = q_r[i];
    end

    always_ff @(posedge clk) begin
      q_r[i+1] <= {q_prev[14:0], take};
    end

    if (i < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[i+1] <= take ? 32'(trial - {1'b0, den_r[i]}) : trial[31:0];
        low_r[i+1] <= {low_r[i][14:0], 1'b0};
        den_r[i+1] <= den_r[i];
      end
    end
  end

  assign code_o = q_r[NS];

endmodule

@@ hw/rtl/mcqp_merge.sv @@
// ----------------------------------------------------------------------------
// mcqp_merge: result packing stage
// Packs the five lane codes big-endian into the 64-bit payload and registers
// the result word with its frame id and strobe.
// ----------------------------------------------------------------------------
module mcqp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic [10:0]          bus_id_i,
  input  mcqp_pkg::codes_t     codes_i,
  output logic                 out_strobe,
  output logic [10:0]          out_bus_id,
  output logic [63:0]          out_payload
);

  logic        strobe_r;
  logic [10:0] bus_id_r;
  logic [63:0] payload_r, payload_nxt;

  // position 16 bits, then four 12-bit codes
  assign payload_nxt = {codes_i.pos,
                        codes_i.vel[11:0],
                        codes_i.stiff[11:0],
                        codes_i.damp[11:0],
                        codes_i.torque[11:0]};

  // strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_i;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    bus_id_r  <= bus_id_i;
    payload_r <= payload_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_bus_id  = bus_id_r;
  assign out_payload = payload_r;

endmodule

@@ tb/tb_mit_command_quantize_pack_unit.sv @@
// ----------------------------------------------------------------------------
// tb_mit_command_quantize_pack_unit: self-checking bench for the command packer
// Drives motor command words through bursty traffic under several range
// settings (reset defaults, full 32-bit spans, empty and inverted ranges,
// one-step ranges, random ranges) and checks every packed frame against a
// behavioral clamp-and-scale model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_mit_command_quantize_pack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // code widths and fixed parts of the frame as the spec defines them
  localparam int unsigned POS_CODE_BITS  = 16;
  localparam int unsigned GAIN_CODE_BITS = 12;
  localparam logic [10:0] ID_OFFSET      = 11'd0;
  localparam longint      GAIN_FLOOR     = 0;

  // range register defaults after reset
  localparam logic signed [31:0] DEF_POS_MIN = -32'sd819200;
  localparam logic signed [31:0] DEF_POS_MAX = 32'sd819200;
  localparam logic signed [31:0] DEF_VEL_MIN = -32'sd1966080;
  localparam logic signed [31:0] DEF_VEL_MAX = 32'sd1966080;
  localparam logic signed [31:0] DEF_TQ_MIN  = -32'sd655360;
  localparam logic signed [31:0] DEF_TQ_MAX  = 32'sd655360;
  localparam logic signed [31:0] DEF_KP_MAX  = 32'sd32768000;
  localparam logic signed [31:0] DEF_KD_MAX  = 32'sd327680;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [10:0]        motor;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] kp;
    logic signed [31:0] kd;
    logic signed [31:0] tq;
  } motor_cmd_t;

  typedef struct packed {
    logic [10:0] bus_id;
    logic [63:0] payload;
  } can_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [10:0] in_motor_number = '0;
  logic signed [31:0] in_target_position = '0;
  logic signed [31:0] in_target_velocity = '0;
  logic signed [31:0] in_stiffness = '0;
  logic signed [31:0] in_damping = '0;
  logic signed [31:0] in_feed_torque = '0;
  logic out_strobe;
  logic [10:0] out_bus_id;
  logic [63:0] out_payload;
  logic cfg_we = 1'b0;
  mcqp_pkg::cfg_reg_t cfg_index = mcqp_pkg::REG_POS_MIN;
  logic [31:0] cfg_wdata = '0;

  // bench copy of the range registers
  logic [31:0] range_regs [8];

  motor_cmd_t pending_cmds[$];
  can_frame_t expected_frames[$];
  int mismatch_count = 0;
  int frames_checked = 0;
  int cmds_sent = 0;
  int settings_used = 1;
  int burst_left = 8;
  int gap_left = 0;

  mit_command_quantize_pack_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_motor_number    (in_motor_number),
    .in_target_position (in_target_position),
    .in_target_velocity (in_target_velocity),
    .in_stiffness       (in_stiffness),
    .in_damping         (in_damping),
    .in_feed_torque     (in_feed_torque),
    .out_strobe         (out_strobe),
    .out_bus_id         (out_bus_id),
    .out_payload        (out_payload),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #4 clk = ~clk;

  // clamp to [lo, hi] and scale onto 0 .. 2^nbits-1, empty range gives 0
  function automatic logic [15:0] scale_code(longint x, longint lo, longint hi,
                                             int unsigned nbits);
    longint full;
    longint code;
    full = (longint'(1) << nbits) - 1;
    if (hi <= lo) return 16'd0;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    code = ((x - lo) * full) / (hi - lo);
    return code[15:0];
  endfunction

  // expected frame for one command under the current ranges
  function automatic can_frame_t pack_frame(motor_cmd_t c);
    can_frame_t f;
    logic [15:0] pos_c, vel_c, kp_c, kd_c, tq_c;
    pos_c = scale_code($signed(c.pos), $signed(range_regs[mcqp_pkg::REG_POS_MIN]),
                       $signed(range_regs[mcqp_pkg::REG_POS_MAX]), POS_CODE_BITS);
    vel_c = scale_code($signed(c.vel), $signed(range_regs[mcqp_pkg::REG_VEL_MIN]),
                       $signed(range_regs[mcqp_pkg::REG_VEL_MAX]), GAIN_CODE_BITS);
    kp_c  = scale_code($signed(c.kp), GAIN_FLOOR,
                       longint'(range_regs[mcqp_pkg::REG_STIFFNESS_MAX][30:0]),
                       GAIN_CODE_BITS);
    kd_c  = scale_code($signed(c.kd), GAIN_FLOOR,
                       longint'(range_regs[mcqp_pkg::REG_DAMPING_MAX][30:0]),
                       GAIN_CODE_BITS);
    tq_c  = scale_code($signed(c.tq), $signed(range_regs[mcqp_pkg::REG_TORQUE_MIN]),
                       $signed(range_regs[mcqp_pkg::REG_TORQUE_MAX]), GAIN_CODE_BITS);
    f.bus_id  = c.motor + ID_OFFSET;
    f.payload = {pos_c, vel_c[11:0], kp_c[11:0], kd_c[11:0], tq_c[11:0]};
    return f;
  endfunction

  // value near a bound, inside the range, or anywhere in 32 bits
  function automatic logic signed [31:0] pick_value(longint lo, longint hi);
    longint v;
    longint unsigned r;
    int mode;
    mode = $urandom_range(0, 9);
    r = {$urandom(), $urandom()};
    case (mode)
      0: v = lo + $signed($urandom_range(0, 4)) - 2;
      1: v = hi + $signed($urandom_range(0, 4)) - 2;
      2: v = $signed($urandom());
      3: v = ($urandom_range(0, 1) == 1) ? longint'(S32_MAX) : longint'(S32_MIN);
      default: begin
        if (hi > lo) v = lo + longint'(r % longint'(hi - lo + 1));
        else v = $signed($urandom());
      end
    endcase
    if (v < longint'(S32_MIN)) v = S32_MIN;
    if (v > longint'(S32_MAX)) v = S32_MAX;
    return v[31:0];
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_cmd(logic [10:0] motor, logic signed [31:0] p, v, k, d, t);
    motor_cmd_t c;
    c = '{motor, p, v, k, d, t};
    pending_cmds.push_back(c);
    cmds_sent++;
  endtask

  // random words shaped by the ranges currently loaded
  task automatic queue_random(int count);
    logic [10:0] motor;
    for (int i = 0; i < count; i++) begin
      motor = $urandom_range(0, 2047);
      if ($urandom_range(0, 15) == 0) motor = ($urandom_range(0, 1) == 1) ? 11'h7ff : 11'h000;
      queue_cmd(motor,
        pick_value($signed(range_regs[mcqp_pkg::REG_POS_MIN]),
                   $signed(range_regs[mcqp_pkg::REG_POS_MAX])),
        pick_value($signed(range_regs[mcqp_pkg::REG_VEL_MIN]),
                   $signed(range_regs[mcqp_pkg::REG_VEL_MAX])),
        pick_value(GAIN_FLOOR,
                   longint'(range_regs[mcqp_pkg::REG_STIFFNESS_MAX][30:0])),
        pick_value(GAIN_FLOOR,
                   longint'(range_regs[mcqp_pkg::REG_DAMPING_MAX][30:0])),
        pick_value($signed(range_regs[mcqp_pkg::REG_TORQUE_MIN]),
                   $signed(range_regs[mcqp_pkg::REG_TORQUE_MAX])));
    end
  endtask

  // wait until every queued word has gone through and every frame came back
  task automatic drain_all();
    while (pending_cmds.size() != 0 || start || expected_frames.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_range(mcqp_pkg::cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == mcqp_pkg::REG_STIFFNESS_MAX || idx == mcqp_pkg::REG_DAMPING_MAX)
      range_regs[idx] = {1'b0, value[30:0]};
    else
      range_regs[idx] = value;
  endtask

  task automatic load_ranges(logic [31:0] p_lo, p_hi, v_lo, v_hi, t_lo, t_hi, k_hi, d_hi);
    write_range(mcqp_pkg::REG_POS_MIN, p_lo);
    write_range(mcqp_pkg::REG_POS_MAX, p_hi);
    write_range(mcqp_pkg::REG_VEL_MIN, v_lo);
    write_range(mcqp_pkg::REG_VEL_MAX, v_hi);
    write_range(mcqp_pkg::REG_TORQUE_MIN, t_lo);
    write_range(mcqp_pkg::REG_TORQUE_MAX, t_hi);
    write_range(mcqp_pkg::REG_STIFFNESS_MAX, k_hi);
    write_range(mcqp_pkg::REG_DAMPING_MAX, d_hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // random bound pair, mostly ordered, sometimes narrow
  task automatic random_pair(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a, b, tmp;
    a = $urandom();
    b = $urandom();
    if ($urandom_range(0, 2) == 0) b = a + $urandom_range(1, 5000);
    if ($signed(a) > $signed(b) && $urandom_range(0, 4) != 0) begin
      tmp = a;
      a = b;
      b = tmp;
    end
    lo = a;
    hi = b;
  endtask

  // sender: bursts of words with random gaps, prediction at acceptance
  always @(posedge clk) begin : driver
    motor_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_frames.push_back(pack_frame('{in_motor_number, in_target_position,
          in_target_velocity, in_stiffness, in_damping, in_feed_torque}));
      if (start && busy) begin
        // word not taken yet, hold it
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        start              <= 1'b1;
        in_motor_number    <= nxt.motor;
        in_target_position <= nxt.pos;
        in_target_velocity <= nxt.vel;
        in_stiffness       <= nxt.kp;
        in_damping         <= nxt.kd;
        in_feed_torque     <= nxt.tq;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // receiver: every strobed word is checked against the oldest prediction
  always @(posedge clk) begin : monitor
    can_frame_t want;
    if (rst_n && out_strobe) begin
      if (expected_frames.size() == 0) begin
        note_mismatch("unexpected word", {53'd0, out_bus_id}, 64'd0);
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (out_bus_id !== want.bus_id)
          note_mismatch("bus_id", {53'd0, out_bus_id}, {53'd0, want.bus_id});
        if (out_payload !== want.payload)
          note_mismatch("payload", out_payload, want.payload);
      end
    end
  end

  // run limit
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [31:0] plo, phi, vlo, vhi, tlo, thi;
    range_regs[mcqp_pkg::REG_POS_MIN]       = DEF_POS_MIN;
    range_regs[mcqp_pkg::REG_POS_MAX]       = DEF_POS_MAX;
    range_regs[mcqp_pkg::REG_VEL_MIN]       = DEF_VEL_MIN;
    range_regs[mcqp_pkg::REG_VEL_MAX]       = DEF_VEL_MAX;
    range_regs[mcqp_pkg::REG_TORQUE_MIN]    = DEF_TQ_MIN;
    range_regs[mcqp_pkg::REG_TORQUE_MAX]    = DEF_TQ_MAX;
    range_regs[mcqp_pkg::REG_STIFFNESS_MAX] = DEF_KP_MAX;
    range_regs[mcqp_pkg::REG_DAMPING_MAX]   = DEF_KD_MAX;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset ranges: bounds, just outside, extremes
    queue_cmd(11'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    queue_cmd(11'h7ff, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    queue_cmd(11'd1, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    queue_cmd(11'd5, DEF_POS_MIN, DEF_VEL_MIN, 32'sd0, 32'sd0, DEF_TQ_MIN);
    queue_cmd(11'd6, DEF_POS_MAX, DEF_VEL_MAX, DEF_KP_MAX, DEF_KD_MAX, DEF_TQ_MAX);
    queue_cmd(11'd7, DEF_POS_MIN - 32'sd1, DEF_VEL_MIN - 32'sd1, -32'sd1, -32'sd1,
              DEF_TQ_MIN - 32'sd1);
    queue_cmd(11'd8, DEF_POS_MAX + 32'sd1, DEF_VEL_MAX + 32'sd1, DEF_KP_MAX + 32'sd1,
              DEF_KD_MAX + 32'sd1, DEF_TQ_MAX + 32'sd1);
    queue_cmd(11'h400, 32'sd0, 32'sd0, DEF_KP_MAX >>> 1, DEF_KD_MAX >>> 1, 32'sd0);
    queue_cmd(11'h555, 32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1);
    queue_cmd(11'h2aa, DEF_POS_MAX - 32'sd1, DEF_VEL_MAX - 32'sd1, DEF_KP_MAX - 32'sd1,
              DEF_KD_MAX - 32'sd1, DEF_TQ_MAX - 32'sd1);
    queue_cmd(11'd100, DEF_POS_MIN + 32'sd1, DEF_VEL_MIN + 32'sd1, 32'sd1, 32'sd1,
              DEF_TQ_MIN + 32'sd1);
    queue_cmd(11'd3, -32'sd12345678, 32'sd777, -32'sd12345678, -32'sd99, 32'sd42);
    queue_random(200);
    drain_all();

    // widest spans, every loaded bound at the 32-bit extremes
    load_ranges(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX,
                32'h7fff_ffff, 32'h7fff_ffff);
    queue_cmd(11'd9, S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MIN);
    queue_cmd(11'd10, S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MAX);
    queue_random(150);
    drain_all();

    // empty and inverted ranges, every code forced to zero
    load_ranges(32'sd5, 32'sd5, 32'sd1000, -32'sd1000, S32_MAX, S32_MIN, 32'd0, 32'd0);
    queue_random(80);
    drain_all();

    // one-step ranges, two steps for damping
    load_ranges(-32'sd3, -32'sd2, S32_MAX - 32'sd1, S32_MAX, -32'sd1, 32'sd0,
                32'd1, 32'd2);
    queue_random(120);
    drain_all();

    // random ranges
    repeat (5) begin
      random_pair(plo, phi);
      random_pair(vlo, vhi);
      random_pair(tlo, thi);
      load_ranges(plo, phi, vlo, vhi, tlo, thi,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9000) : $urandom(),
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9000) : $urandom());
      queue_random(120);
      drain_all();
    end

    // let any stray word show up before closing
    repeat (mcqp_pkg::TOTAL_LAT + 8) @(posedge clk);
    if (expected_frames.size() != 0)
      note_mismatch("words never returned", 64'(expected_frames.size()), 64'd0);

    $display("sent %0d command words across %0d range settings, checked %0d frames",
             cmds_sent, settings_used, frames_checked);
    $display("%0d mismatches found", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
